// File: hw/rtl/lens_undistort_source_coordinate_top_defines.svh
// Assertion macros used by the block's top-level RTL.
`ifndef LENS_UNDISTORT_SOURCE_COORDINATE_TOP_DEFINES_SVH
`define LENS_UNDISTORT_SOURCE_COORDINATE_TOP_DEFINES_SVH

// Check a same-cycle implication on clk_i, quiet while rst_ni is low.
`define LUSC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lusc assertion failed");

// Check a next-cycle implication on clk_i, quiet while rst_ni is low.
`define LUSC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lusc assertion failed");

`endif

// File: hw/rtl/lusc_pkg.sv
package lusc_pkg;

  typedef enum logic [2:0] {
    CFG_FOCAL_X,
    CFG_FOCAL_Y,
    CFG_CENTER_X,
    CFG_CENTER_Y,
    CFG_RADIAL_K1,
    CFG_RADIAL_K2,
    CFG_TANGENTIAL_P1,
    CFG_TANGENTIAL_P2
  } cfg_idx_e;

  localparam int unsigned CRD_W     = 12;
  localparam int unsigned PIX_W     = 20;
  localparam int unsigned COEF_W    = 32;
  localparam int unsigned DIFF_W    = 21;
  localparam int unsigned NORM_W    = 33;
  localparam int unsigned FRAC_BITS = 30;

  localparam int unsigned DIV_LAT    = NORM_W + 1;
  localparam int unsigned MUL_LAT    = 3;
  localparam int unsigned PIPE_DEPTH = DIV_LAT + 5 * MUL_LAT + 3;

  localparam logic [PIX_W-1:0]  RST_FOCAL_X  = 20'd117414;
  localparam logic [PIX_W-1:0]  RST_FOCAL_Y  = 20'd117066;
  localparam logic [PIX_W-1:0]  RST_CENTER_X = 20'd94006;
  localparam logic [PIX_W-1:0]  RST_CENTER_Y = 20'd63583;
  localparam logic [COEF_W-1:0] RST_K1       = 32'hEDDCC63F;
  localparam logic [COEF_W-1:0] RST_K2       = 32'd79349521;
  localparam logic [COEF_W-1:0] RST_P1       = 32'd204011;
  localparam logic [COEF_W-1:0] RST_P2       = 32'd18898;

  localparam logic [COEF_W-1:0] ONE_Q30 = 32'h4000_0000;

endpackage

// File: hw/rtl/lens_undistort_source_coordinate_top.sv
// Maps each output pixel (dest_col, dest_row) to its source pixel in the distorted image
// under the radial/tangential lens model, one word per clock cycle while the output does
// not stall. The pipeline depth is set by the two normalizing dividers (one quotient bit
// per stage, 34 stages) followed by five three-stage multiplier ranks. A word held at the
// output under a low m_axis_tready freezes the whole pipeline and drops s_axis_tready.
// Write the configuration registers only while no word is in flight.
`include "lens_undistort_source_coordinate_top_defines.svh"

module lens_undistort_source_coordinate_top #(
  parameter int unsigned IMAGE_WIDTH  = 752,
  parameter int unsigned IMAGE_HEIGHT = 480
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // dest_col[11:0], dest_row[23:12]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // src_col[11:0], src_row[23:12]
  output logic        m_axis_tuser    // inside_res[0]
);

  localparam int unsigned CW = lusc_pkg::CRD_W;
  localparam int unsigned PW = lusc_pkg::PIX_W;
  localparam int unsigned KW = lusc_pkg::COEF_W;
  localparam int unsigned NW = lusc_pkg::NORM_W;
  localparam int unsigned ML = lusc_pkg::MUL_LAT;
  localparam int unsigned PD = lusc_pkg::PIPE_DEPTH;
  localparam int unsigned UW = 38;
  localparam logic signed [UW-1:0] ColLim = UW'(IMAGE_WIDTH * 256);
  localparam logic signed [UW-1:0] RowLim = UW'(IMAGE_HEIGHT * 256);

  logic [PW-1:0]        focal_x_q, focal_y_q, center_x_q, center_y_q;
  logic signed [KW-1:0] k1_q, k2_q, p1_q, p2_q;

  logic en;
  logic vld_q [PD];
  logic out_vld_q;
  logic [23:0] out_data_q;
  logic out_ins_q;

  logic signed [lusc_pkg::DIFF_W-1:0] dx, dy;
  logic signed [NW-1:0] x, y;
  logic signed [35:0] x2, y2, xy;
  logic signed [36:0] r2_q;
  logic signed [37:0] ax_q, ay_q;
  logic signed [35:0] xy_q;
  logic signed [41:0] r4;
  logic signed [37:0] k1r2, tx1, ty1;
  logic signed [38:0] tx2, ty2;
  logic signed [39:0] tsx, tsy;
  logic signed [42:0] k2r4;
  logic [37:0] k1r2_dl;
  logic [39:0] tsx_dl, tsy_dl;
  logic [NW-1:0] x_dl, y_dl;
  logic signed [43:0] rad_q;
  logic signed [45:0] xr, yr;
  logic signed [46:0] xd_q, yd_q;
  logic signed [36:0] fxd, fyd;
  logic signed [UW-1:0] ud, vd;
  logic in_img;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= lusc_pkg::RST_FOCAL_X;
      focal_y_q  <= lusc_pkg::RST_FOCAL_Y;
      center_x_q <= lusc_pkg::RST_CENTER_X;
      center_y_q <= lusc_pkg::RST_CENTER_Y;
      k1_q       <= lusc_pkg::RST_K1;
      k2_q       <= lusc_pkg::RST_K2;
      p1_q       <= lusc_pkg::RST_P1;
      p2_q       <= lusc_pkg::RST_P2;
    end else if (cfg_we_i) begin
      unique case (lusc_pkg::cfg_idx_e'(cfg_idx_i))
        lusc_pkg::CFG_FOCAL_X:       focal_x_q  <= cfg_wdata_i[PW-1:0];
        lusc_pkg::CFG_FOCAL_Y:       focal_y_q  <= cfg_wdata_i[PW-1:0];
        lusc_pkg::CFG_CENTER_X:      center_x_q <= cfg_wdata_i[PW-1:0];
        lusc_pkg::CFG_CENTER_Y:      center_y_q <= cfg_wdata_i[PW-1:0];
        lusc_pkg::CFG_RADIAL_K1:     k1_q       <= cfg_wdata_i;
        lusc_pkg::CFG_RADIAL_K2:     k2_q       <= cfg_wdata_i;
        lusc_pkg::CFG_TANGENTIAL_P1: p1_q       <= cfg_wdata_i;
        lusc_pkg::CFG_TANGENTIAL_P2: p2_q       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // flow control
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PD; i++) begin
        vld_q[i] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid;
      for (int i = 1; i < PD; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
      out_vld_q <= vld_q[PD-1];
    end
  end

  // normalize
  assign dx = $signed({1'b0, s_axis_tdata[CW-1:0], 8'b0}) - $signed({1'b0, center_x_q});
  assign dy = $signed({1'b0, s_axis_tdata[2*CW-1:CW], 8'b0}) - $signed({1'b0, center_y_q});

  lusc_div u_div_x (.clk_i, .en_i(en), .diff_i(dx), .focal_i(focal_x_q), .quot_o(x));
  lusc_div u_div_y (.clk_i, .en_i(en), .diff_i(dy), .focal_i(focal_y_q), .quot_o(y));

  // squares and cross term
  lusc_mul #(.AW(NW), .BW(NW), .PW(36)) u_mul_x2 (.clk_i, .en_i(en), .a_i(x), .b_i(x), .p_o(x2));
  lusc_mul #(.AW(NW), .BW(NW), .PW(36)) u_mul_y2 (.clk_i, .en_i(en), .a_i(y), .b_i(y), .p_o(y2));
  lusc_mul #(.AW(NW), .BW(NW), .PW(36)) u_mul_xy (.clk_i, .en_i(en), .a_i(x), .b_i(y), .p_o(xy));

  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_q <= 37'(x2) + 37'(y2);
      ax_q <= 38'(x2) + 38'(y2) + (38'(x2) <<< 1);
      ay_q <= 38'(x2) + 38'(y2) + (38'(y2) <<< 1);
      xy_q <= xy;
    end
  end

  // radial and tangential products
  lusc_mul #(.AW(37), .BW(37), .PW(42)) u_mul_r4 (
    .clk_i, .en_i(en), .a_i(r2_q), .b_i(r2_q), .p_o(r4));
  lusc_mul #(.AW(KW), .BW(37), .PW(38)) u_mul_k1 (
    .clk_i, .en_i(en), .a_i(k1_q), .b_i(r2_q), .p_o(k1r2));
  lusc_mul #(.AW(KW+1), .BW(36), .PW(38)) u_mul_tx1 (
    .clk_i, .en_i(en), .a_i({p1_q, 1'b0}), .b_i(xy_q), .p_o(tx1));
  lusc_mul #(.AW(KW), .BW(38), .PW(39)) u_mul_tx2 (
    .clk_i, .en_i(en), .a_i(p2_q), .b_i(ax_q), .p_o(tx2));
  lusc_mul #(.AW(KW+1), .BW(36), .PW(38)) u_mul_ty1 (
    .clk_i, .en_i(en), .a_i({p2_q, 1'b0}), .b_i(xy_q), .p_o(ty1));
  lusc_mul #(.AW(KW), .BW(38), .PW(39)) u_mul_ty2 (
    .clk_i, .en_i(en), .a_i(p1_q), .b_i(ay_q), .p_o(ty2));

  assign tsx = 40'(tx1) + 40'(tx2);
  assign tsy = 40'(ty1) + 40'(ty2);

  lusc_mul #(.AW(KW), .BW(42), .PW(43)) u_mul_k2 (
    .clk_i, .en_i(en), .a_i(k2_q), .b_i(r4), .p_o(k2r4));

  lusc_dly #(.W(38), .N(ML)) u_dly_k1 (.clk_i, .en_i(en), .d_i(k1r2), .q_o(k1r2_dl));
  lusc_dly #(.W(40), .N(2*ML+1)) u_dly_tx (.clk_i, .en_i(en), .d_i(tsx), .q_o(tsx_dl));
  lusc_dly #(.W(40), .N(2*ML+1)) u_dly_ty (.clk_i, .en_i(en), .d_i(tsy), .q_o(tsy_dl));
  lusc_dly #(.W(NW), .N(3*ML+2)) u_dly_x (.clk_i, .en_i(en), .d_i(x), .q_o(x_dl));
  lusc_dly #(.W(NW), .N(3*ML+2)) u_dly_y (.clk_i, .en_i(en), .d_i(y), .q_o(y_dl));

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q <= 44'($signed(k1r2_dl)) + 44'(k2r4) + 44'(lusc_pkg::ONE_Q30);
    end
  end

  // distorted normalized point
  lusc_mul #(.AW(NW), .BW(44), .PW(46)) u_mul_xr (
    .clk_i, .en_i(en), .a_i($signed(x_dl)), .b_i(rad_q), .p_o(xr));
  lusc_mul #(.AW(NW), .BW(44), .PW(46)) u_mul_yr (
    .clk_i, .en_i(en), .a_i($signed(y_dl)), .b_i(rad_q), .p_o(yr));

  always_ff @(posedge clk_i) begin
    if (en) begin
      xd_q <= 47'(xr) + 47'($signed(tsx_dl));
      yd_q <= 47'(yr) + 47'($signed(tsy_dl));
    end
  end

  // back to pixels
  lusc_mul #(.AW(PW+1), .BW(47), .PW(37)) u_mul_u (
    .clk_i, .en_i(en), .a_i($signed({1'b0, focal_x_q})), .b_i(xd_q), .p_o(fxd));
  lusc_mul #(.AW(PW+1), .BW(47), .PW(37)) u_mul_v (
    .clk_i, .en_i(en), .a_i($signed({1'b0, focal_y_q})), .b_i(yd_q), .p_o(fyd));

  assign ud     = UW'(fxd) + UW'($signed({1'b0, center_x_q}));
  assign vd     = UW'(fyd) + UW'($signed({1'b0, center_y_q}));
  assign in_img = !ud[UW-1] && !vd[UW-1] && (ud < ColLim) && (vd < RowLim);

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= in_img ? {vd[CW+7:8], ud[CW+7:8]} : '0;
      out_ins_q  <= in_img;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ins_q;

  `LUSC_ASSERT_IMP(a_outside_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)
  `LUSC_ASSERT_IMP(a_inside_bounds, m_axis_tvalid && m_axis_tuser,
                   (32'(m_axis_tdata[CW-1:0]) < IMAGE_WIDTH) &&
                   (32'(m_axis_tdata[2*CW-1:CW]) < IMAGE_HEIGHT))
  `LUSC_ASSERT_NXT(a_accept_enters, s_axis_tvalid && s_axis_tready, vld_q[0])

endmodule

// File: hw/rtl/lusc_dly.sv
module lusc_dly #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  assign q_o = sr_q[N-1];

endmodule

// File: hw/rtl/lusc_mul.sv
module lusc_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 32,
  parameter int unsigned PW = 32
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic signed [PW-1:0] p_o
);

  localparam int unsigned AL = AW / 2;
  localparam int unsigned AH = AW - AL;
  localparam int unsigned BL = BW / 2;
  localparam int unsigned BH = BW - BL;
  localparam int unsigned FW = AW + BW;

  logic signed [AH-1:0]    ah;
  logic        [AL-1:0]    al;
  logic signed [BH-1:0]    bh;
  logic        [BL-1:0]    bl;
  logic signed [AH+BH-1:0] hh_q;
  logic signed [AH+BL:0]   hl_q;
  logic signed [AL+BH:0]   lh_q;
  logic        [AL+BL-1:0] ll_q;
  logic signed [FW-1:0]    hi_q;
  logic signed [FW-1:0]    lo_q;
  logic signed [FW-1:0]    sum;
  logic signed [PW-1:0]    p_q;

  assign ah = a_i[AW-1:AL];
  assign al = a_i[AL-1:0];
  assign bh = b_i[BW-1:BL];
  assign bl = b_i[BL-1:0];

  // partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q <= ah * bh;
      hl_q <= ah * $signed({1'b0, bl});
      lh_q <= $signed({1'b0, al}) * bh;
      ll_q <= al * bl;
    end
  end

  // align and pair
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hi_q <= (FW'(hh_q) <<< (AL + BL)) + (FW'(hl_q) <<< AL);
      lo_q <= (FW'(lh_q) <<< BL) + FW'(ll_q);
    end
  end

  // sum and floor-scale
  assign sum = hi_q + lo_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= PW'(sum >>> lusc_pkg::FRAC_BITS);
    end
  end

  assign p_o = p_q;

endmodule

// File: hw/rtl/lusc_div.sv
module lusc_div (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [lusc_pkg::DIFF_W-1:0] diff_i,
  input  logic        [lusc_pkg::PIX_W-1:0]  focal_i,
  output logic signed [lusc_pkg::NORM_W-1:0] quot_o
);

  localparam int unsigned PW = lusc_pkg::PIX_W;
  localparam int unsigned DW = lusc_pkg::DIFF_W;
  localparam int unsigned QW = lusc_pkg::NORM_W - 1;

  logic [PW-1:0] fdiv;
  logic [PW-1:0] mag;

  logic [PW-1:0] rem_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic [1:0]    low_q [QW+1];
  logic          neg_q [QW+1];
  logic          sat_q [QW+1];

  logic [QW:0]   qc;
  logic [QW-1:0] qm;
  logic signed [lusc_pkg::NORM_W-1:0] quot_q;

  assign fdiv = (focal_i == '0) ? PW'(1) : focal_i;
  assign mag  = diff_i[DW-1] ? PW'(-diff_i) : PW'(diff_i);

  // prepare: quotient overflows 32 bits when mag >= 4 * focal
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= PW'(mag >> 2);
      low_q[0] <= mag[1:0];
      neg_q[0] <= diff_i[DW-1];
      sat_q[0] <= ({2'b00, mag} >= {fdiv, 2'b00});
      quo_q[0] <= '0;
    end
  end

  for (genvar i = 1; i <= QW; i++) begin : g_step
    logic [PW:0] trial;
    logic [PW:0] rest;
    logic        take;

    always_comb begin
      trial = {rem_q[i-1], low_q[i-1][1]};
      rest  = trial - {1'b0, fdiv};
      take  = (trial >= {1'b0, fdiv});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= take ? rest[PW-1:0] : trial[PW-1:0];
        quo_q[i] <= {quo_q[i-1][QW-2:0], take};
        low_q[i] <= {low_q[i-1][0], 1'b0};
        neg_q[i] <= neg_q[i-1];
        sat_q[i] <= sat_q[i-1];
      end
    end
  end

  // round toward minus infinity for negative offsets, then clamp
  always_comb begin
    qc = {1'b0, quo_q[QW]} + (QW+1)'(neg_q[QW] && (rem_q[QW] != '0));
    qm = (sat_q[QW] || qc[QW]) ? {QW{1'b1}} : qc[QW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q <= neg_q[QW] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
    end
  end

  assign quot_o = quot_q;

endmodule
